FILE: hdl/text_console_char_writer_core_macros.svh
// Assertion helpers for the console core.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked on i_clk, quiet during reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry (both powers of two: rows wrap in the row offset add)
    localparam int NUM_COLS = 64;
    localparam int NUM_ROWS = 32;
    localparam int COL_W    = $clog2(NUM_COLS);
    localparam int ROW_W    = $clog2(NUM_ROWS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int CHAR_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_COL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ROW = 1'b1;

    // Operations
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_CLEARLEFT = 8'd2;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

    // Controller -> datapath
    typedef struct packed {
        logic load;    // capture the accepted item
        logic exec;    // decode, issue cell read, reset sweep counter
        logic sweep;   // clear one cell of the cursor row
        logic finish;  // final write, cursor update, result out
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
    } t_stat;

endpackage

`default_nettype wire

FILE: hdl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_cmd      o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_sweep ? S_SWEEP : S_FINISH;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tcw_pkg::t_cmd                  i_cmd,
    output tcw_pkg::t_stat                      o_stat,
    input  wire logic                           i_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcw_pkg::ROW_W-1:0]      i_read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]      i_read_col,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_done,
    output logic      [tcw_pkg::CHAR_W-1:0]     o_read_char,
    output logic      [tcw_pkg::COL_W-1:0]      o_cursor_col,
    output logic      [tcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic                                o_scrolled
);
    import tcw_pkg::*;

    // latched item
    logic              r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [ROW_W-1:0]  r_rrow;
    logic [COL_W-1:0]  r_rcol;

    // console state
    logic [COL_W-1:0]  r_ccol, n_ccol;
    logic [ROW_W-1:0]  r_crow, n_crow;
    logic [ROW_W-1:0]  r_base;           // physical row shown as row zero
    logic              r_row_vld [NUM_ROWS];
    logic [COL_W-1:0]  r_mark_col;
    logic [ROW_W-1:0]  r_mark_row;
    logic [COL_W-1:0]  r_cnt;
    logic              r_rd_ok;

    logic              is_read, is_put, is_nl, is_bs, is_clrl, is_ret, is_print;
    logic              bs_ok, vld_cur, do_scroll;
    logic [ROW_W-1:0]  cur_phys, rd_phys;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;

    // decode
    assign is_read  = (r_op == OP_READ);
    assign is_put   = (r_op == OP_PUT);
    assign is_nl    = is_put && (r_ch == CH_NEWLINE);
    assign is_bs    = is_put && (r_ch == CH_BACKSPACE);
    assign is_clrl  = is_put && (r_ch == CH_CLEARLEFT);
    assign is_ret   = is_put && (r_ch == CH_RETURN);
    assign is_print = is_put && !is_nl && !is_bs && !is_clrl && !is_ret;

    // linear positions compare as {row, col} since the width is a power of two
    assign bs_ok    = ({r_mark_row, r_mark_col} < {r_crow, r_ccol});

    // logical to physical row through the scroll offset
    assign cur_phys = r_crow + r_base;
    assign rd_phys  = r_rrow + r_base;
    assign vld_cur  = r_row_vld[cur_phys];

    // a row not touched since reset or scroll reads as blank; clear it
    // before the first print into it
    assign o_stat.need_sweep = (is_print && !vld_cur)
                             || (is_clrl && vld_cur && (r_ccol != '0));
    assign o_stat.sweep_last = is_print ? (r_cnt == LAST_COL)
                                        : (r_cnt == COL_W'(r_ccol - COL_W'(1)));

    // cell store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {cur_phys, r_ccol};
        ram_wdata = r_ch;
        if (i_cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = {cur_phys, r_cnt};
            ram_wdata = '0;
        end else if (i_cmd.finish) begin
            ram_we    = is_print || (is_bs && bs_ok);
            ram_wdata = is_print ? r_ch : '0;
        end
    end
    assign ram_raddr = {rd_phys, r_rcol};

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (NUM_ROWS * NUM_COLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.exec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // cursor update
    always_comb begin
        n_ccol    = r_ccol;
        n_crow    = r_crow;
        do_scroll = 1'b0;
        if (is_nl || (is_print && (r_ccol == LAST_COL))) begin
            n_ccol = '0;
            if (r_crow == LAST_ROW) begin
                do_scroll = 1'b1;
            end else begin
                n_crow = ROW_W'(r_crow + ROW_W'(1));
            end
        end else if (is_print) begin
            n_ccol = COL_W'(r_ccol + COL_W'(1));
        end else if (is_bs && bs_ok) begin
            if (r_ccol != '0) begin
                n_ccol = COL_W'(r_ccol - COL_W'(1));
            end else begin
                n_ccol = LAST_COL;
                n_crow = ROW_W'(r_crow - ROW_W'(1));
            end
        end else if (is_clrl || is_ret) begin
            n_ccol = '0;
        end
    end

    // item latch, sweep counter, read qualifier
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_ch   <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.exec) begin
            r_cnt   <= '0;
            r_rd_ok <= r_row_vld[rd_phys]
                    && (32'(r_rrow) < NUM_ROWS) && (32'(r_rcol) < NUM_COLS);
        end else if (i_cmd.sweep) begin
            r_cnt <= COL_W'(r_cnt + COL_W'(1));
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_read_char  <= (is_read && r_rd_ok) ? ram_rdata : '0;
            o_cursor_col <= n_ccol;
            o_cursor_row <= n_crow;
            o_scrolled   <= do_scroll;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccol     <= '0;
            r_crow     <= '0;
            r_base     <= '0;
            r_mark_col <= '0;
            r_mark_row <= '0;
            o_done     <= 1'b0;
            for (int i = 0; i < NUM_ROWS; i++) begin
                r_row_vld[i] <= 1'b0;
            end
        end else begin
            o_done <= i_cmd.finish;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MARK_COL: r_mark_col <= i_cfg_data[COL_W-1:0];
                    CFG_MARK_ROW: r_mark_row <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            // row cleared by sweep is now live
            if (i_cmd.sweep && o_stat.sweep_last && is_print) begin
                r_row_vld[cur_phys] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_ccol <= n_ccol;
                r_crow <= n_crow;
                // scroll: old top row becomes the blank bottom row
                if (do_scroll) begin
                    r_base            <= ROW_W'(r_base + ROW_W'(1));
                    r_row_vld[r_base] <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/text_console_char_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Character-cell text console core, 32 rows by 64 columns of byte cells.
// Items: raise start with the item fields while busy is low; the item is
// taken at that edge. A put item (opcode 0) prints or interprets a byte;
// a read item (opcode 1) returns one cell. Each item gives one result,
// shown for exactly one cycle with o_done high; the receiver cannot stall.
// Flow: each item passes an exec state and a finish state, after which
// o_done rises. Clear-left on a live row first sweeps the cells left of the
// cursor; the first print into a row blank since reset or a scroll first
// sweeps the whole row, one cell a cycle through the cell RAM write port.
// busy falls in the o_done cycle, so a new item can be taken then and not
// before. Scrolling rotates a row offset and needs no sweep of its own.
// Configuration: i_cfg_we writes mark_col (index 0) or mark_row (index 1)
// from i_cfg_data at once; write only while idle.
// Reset: synchronous, active low; cursor, marks and row offset go to zero
// and every row reads blank at once, with no clearing pass.
module text_console_char_writer_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcw_pkg::ROW_W-1:0]      i_read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]      i_read_col,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_done,
    output logic      [tcw_pkg::CHAR_W-1:0]     o_read_char,
    output logic      [tcw_pkg::COL_W-1:0]      o_cursor_col,
    output logic      [tcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic                                o_scrolled
);
    import tcw_pkg::*;

`include "text_console_char_writer_core_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_read_char  (o_read_char),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

    // checks
    `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `TCW_ASSERT_NOW(a_done_after_busy, o_done, $past(busy), "result without an item in work")
    `TCW_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe held two cycles")
    `TCW_ASSERT_NOW(a_scroll_cursor, o_done && o_scrolled,
        (o_cursor_col == '0) && (o_cursor_row == LAST_ROW), "scroll left cursor off bottom row")

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    // One expected result of the console: the cell read back and the cursor after the item
    typedef struct packed {
        logic [CHAR_W-1:0] rd_char;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
    } cursor_report_t;

    // Mirror of the screen, cursor and protected mark; queues the reports it predicts
    class console_mirror;
        logic [CHAR_W-1:0] cells [NUM_ROWS][NUM_COLS];
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  mark_col;
        logic [ROW_W-1:0]  mark_row;
        cursor_report_t    pending_reports [$];
        int                errors;

        function new();
            for (int r = 0; r < NUM_ROWS; r++)
                for (int c = 0; c < NUM_COLS; c++)
                    cells[r][c] = '0;
            cur_col  = '0;
            cur_row  = '0;
            mark_col = '0;
            mark_row = '0;
            errors   = 0;
        endfunction

        function void set_mark(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MARK_COL)
                mark_col = data[COL_W-1:0];
            else
                mark_row = data[ROW_W-1:0];
        endfunction

        // Every row moves up, the bottom row goes blank, column homes
        function void scroll_screen();
            for (int r = 0; r < NUM_ROWS - 1; r++)
                for (int c = 0; c < NUM_COLS; c++)
                    cells[r][c] = cells[r+1][c];
            for (int c = 0; c < NUM_COLS; c++)
                cells[NUM_ROWS-1][c] = '0;
            cur_col = '0;
        endfunction

        function void take_item(logic op, logic [CHAR_W-1:0] ch,
                                logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
            cursor_report_t rep;
            int mark_pos;
            int cur_pos;
            rep = '0;
            if (op == OP_READ) begin
                rep.rd_char = cells[rr][rc];
            end else begin
                case (ch)
                    CH_NEWLINE: begin
                        if (cur_row == LAST_ROW) begin
                            scroll_screen();
                            rep.scrolled = 1'b1;
                        end else begin
                            cur_col = '0;
                            cur_row++;
                        end
                    end
                    CH_BACKSPACE: begin
                        // only past the protected mark; clear under cursor, then step back
                        mark_pos = mark_row * NUM_COLS + mark_col;
                        cur_pos  = cur_row * NUM_COLS + cur_col;
                        if (mark_pos < cur_pos) begin
                            cells[cur_row][cur_col] = '0;
                            if (cur_col != 0) begin
                                cur_col--;
                            end else begin
                                cur_col = LAST_COL;
                                cur_row--;
                            end
                        end
                    end
                    CH_CLEARLEFT: begin
                        for (int c = 0; c < cur_col; c++)
                            cells[cur_row][c] = '0;
                        cur_col = '0;
                    end
                    CH_RETURN: begin
                        cur_col = '0;
                    end
                    default: begin
                        cells[cur_row][cur_col] = ch;
                        if (cur_col == LAST_COL) begin
                            if (cur_row == LAST_ROW) begin
                                scroll_screen();
                                rep.scrolled = 1'b1;
                            end else begin
                                cur_col = '0;
                                cur_row++;
                            end
                        end else begin
                            cur_col++;
                        end
                    end
                endcase
            end
            rep.col = cur_col;
            rep.row = cur_row;
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
            if (act_val !== exp_val) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_report(logic [CHAR_W-1:0] rd_char, logic [COL_W-1:0] col,
                                   logic [ROW_W-1:0] row, logic scrolled);
            cursor_report_t exp_rep;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: result with no item outstanding: char %0d col %0d row %0d",
                         $time, rd_char, col, row);
                return;
            end
            // oldest outstanding report
            exp_rep = pending_reports[0];
            pending_reports.delete(0);
            compare_field("read_char", exp_rep.rd_char, rd_char);
            compare_field("cursor_col", 8'(exp_rep.col), 8'(col));
            compare_field("cursor_row", 8'(exp_rep.row), 8'(row));
            compare_field("scrolled", 8'(exp_rep.scrolled), 8'(scrolled));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_opcode;
    logic [CHAR_W-1:0]     i_char_code;
    logic [ROW_W-1:0]      i_read_row;
    logic [COL_W-1:0]      i_read_col;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic [CHAR_W-1:0]     o_read_char;
    logic [COL_W-1:0]      o_cursor_col;
    logic [ROW_W-1:0]      o_cursor_row;
    logic                  o_scrolled;

    console_mirror mirror;
    int            items_sent;

    text_console_char_writer_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_read_char  (o_read_char),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

    always #5 i_clk = ~i_clk;

    // Results first: the result of the older item may share an edge with a new accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                mirror.check_report(o_read_char, o_cursor_col, o_cursor_row, o_scrolled);
            if (start && !busy)
                mirror.take_item(i_opcode, i_char_code, i_read_row, i_read_col);
        end
    end

    // Present one item and hold it until the accepting edge
    task automatic send_item(logic op, logic [CHAR_W-1:0] ch,
                             logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        @(negedge i_clk);
        start       = 1'b1;
        i_opcode    = op;
        i_char_code = ch;
        i_read_row  = rr;
        i_read_col  = rc;
        do @(posedge i_clk); while (busy);
    endtask

    // Sender idle; fields carry junk while start is low
    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        start       = 1'b0;
        i_opcode    = 1'($urandom);
        i_char_code = 8'($urandom);
        i_read_row  = 5'($urandom);
        i_read_col  = 6'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Wait until every outstanding item has reported, plus a short margin
    task automatic drain();
        pause_sender(1);
        while (mirror.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mark(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        mirror.set_mark(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic issue(logic op, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] rr,
                         logic [COL_W-1:0] rc, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 13));
        send_item(op, ch, rr, rc);
        items_sent++;
    endtask

    // One well-formed run of console traffic with random content
    task automatic random_burst(bit gaps);
        int kind;
        int n;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // text run, long enough at times to wrap past the right edge
            n = $urandom_range(1, 70);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0)
                    ch = 8'($urandom);
                else
                    ch = 8'($urandom_range(32, 126));
                issue(OP_PUT, ch, 5'($urandom), 6'($urandom), gaps);
            end
        end else if (kind < 55) begin
            n = $urandom_range(1, 8);
            repeat (n) issue(OP_PUT, CH_NEWLINE, 5'($urandom), 6'($urandom), gaps);
        end else if (kind < 67) begin
            n = $urandom_range(1, 80);
            repeat (n) issue(OP_PUT, CH_BACKSPACE, 5'($urandom), 6'($urandom), gaps);
        end else if (kind < 75) begin
            ch = $urandom_range(0, 1) ? CH_RETURN : CH_CLEARLEFT;
            issue(OP_PUT, ch, 5'($urandom), 6'($urandom), gaps);
        end else begin
            // read back mostly the cursor row, where text just landed
            n = $urandom_range(1, 6);
            repeat (n) begin
                rr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : mirror.cur_row;
                issue(OP_READ, 8'($urandom), rr, 6'($urandom), gaps);
            end
        end
    endtask

    initial begin
        mirror      = new();
        items_sent  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = OP_PUT;
        i_char_code = '0;
        i_read_row  = '0;
        i_read_col  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MARK_COL;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: blank reads, edge bytes, controls at home, mark boundary
        write_mark(CFG_MARK_COL, 6'd0);
        write_mark(CFG_MARK_ROW, 6'd0);
        send_item(OP_READ, 8'h00, 5'd0, 6'd0);
        send_item(OP_READ, 8'hFF, LAST_ROW, LAST_COL);
        send_item(OP_PUT, CH_BACKSPACE, 5'd0, 6'd0);   // at home: no effect
        send_item(OP_PUT, 8'hFF, 5'd0, 6'd0);
        send_item(OP_PUT, 8'h00, 5'd0, 6'd0);          // zero byte prints a blank
        send_item(OP_PUT, 8'h41, 5'd0, 6'd0);
        send_item(OP_READ, 8'h00, 5'd0, 6'd0);
        send_item(OP_PUT, CH_BACKSPACE, 5'd0, 6'd0);
        send_item(OP_READ, 8'h00, 5'd0, 6'd2);
        send_item(OP_PUT, CH_CLEARLEFT, 5'd0, 6'd0);
        send_item(OP_READ, 8'h00, 5'd0, 6'd0);
        send_item(OP_PUT, 8'h42, 5'd0, 6'd0);
        send_item(OP_PUT, CH_RETURN, 5'd0, 6'd0);
        send_item(OP_PUT, CH_NEWLINE, 5'd0, 6'd0);
        send_item(OP_PUT, CH_BACKSPACE, 5'd0, 6'd0);   // wraps to end of row zero
        send_item(OP_READ, 8'h00, 5'd0, LAST_COL);
        write_mark(CFG_MARK_COL, 6'(LAST_COL));
        send_item(OP_PUT, CH_BACKSPACE, 5'd0, 6'd0);   // cursor on the mark: blocked
        send_item(OP_PUT, 8'h7E, 5'd0, 6'd0);          // right edge wraps a row
        send_item(OP_READ, 8'h00, 5'd0, LAST_COL);
        send_item(OP_PUT, 8'h80, 5'd0, 6'd0);
        send_item(OP_PUT, CH_NEWLINE, 5'd0, 6'd0);
        send_item(OP_PUT, CH_CLEARLEFT, 5'd0, 6'd0);   // at column zero: nothing to clear

        // Random phases, each under its own mark; the last one runs without gaps
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_mark(CFG_MARK_COL, 6'h3F);
                    write_mark(CFG_MARK_ROW, 6'h3F);
                end
                1: begin
                    write_mark(CFG_MARK_COL, 6'($urandom));
                    write_mark(CFG_MARK_ROW, 6'($urandom));
                end
                2: begin
                    write_mark(CFG_MARK_COL, 6'd0);
                    write_mark(CFG_MARK_ROW, 6'd0);
                end
                default: begin
                    drain();
                    write_mark(CFG_MARK_COL, 6'(mirror.cur_col));
                    write_mark(CFG_MARK_ROW, 6'(mirror.cur_row));
                end
            endcase
            items_sent = 0;
            while (items_sent < 500)
                random_burst(phase < 3 && $urandom_range(0, 2) != 0);
        end

        // Let the last items report; a print into a blank row also sweeps that row
        drain();
        repeat (80) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: text_console_char_writer_core.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_char_writer_core.sv
test/tb.sv
